/* hdl/srt_pkg.sv */
// Shared constants, codes and types of the sorted region table.
`default_nettype none

package srt_pkg;

   localparam int DEF_MAX_REGIONS = 16;
   localparam int DEF_ADDR_BITS   = 48;
   localparam int DEF_FLAG_BITS   = 16;
   localparam int QUEUE_DEPTH     = 2;
   localparam int OP_BITS         = 2;
   localparam int STATUS_BITS     = 3;

   localparam logic [OP_BITS-1:0] OP_LOOKUP = 2'd0;
   localparam logic [OP_BITS-1:0] OP_INSERT = 2'd1;
   localparam logic [OP_BITS-1:0] OP_CLEAR  = 2'd2;

   localparam logic [STATUS_BITS-1:0] STATUS_OK        = 3'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_NOT_FOUND = 3'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_EMPTY     = 3'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_OVERLAP   = 3'd3;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL      = 3'd4;

   typedef enum logic [1:0] {
      KIND_LOOKUP,
      KIND_INSERT,
      KIND_CLEAR,
      KIND_NOP
   } srt_kind_type;

   typedef struct packed {
      srt_kind_type kind;
      logic         empty_range;
   } srt_tag_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LK_CACHE,
      S_LK_CHECK,
      S_LK_SCAN,
      S_IN_SCAN,
      S_IN_DECIDE,
      S_IN_SHIFT,
      S_IN_PLACE
   } srt_state_type;

endpackage

`default_nettype wire

/* hdl/srt_front.sv */
// Command front end: accepts beats, classifies them and queues them for the back end.
`default_nettype none

module srt_front #(
   parameter int ADDR_BITS = srt_pkg::DEF_ADDR_BITS,
   parameter int FLAG_BITS = srt_pkg::DEF_FLAG_BITS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [srt_pkg::OP_BITS-1:0] req_operation,
   input  logic [ADDR_BITS-1:0]       req_lookup_address,
   input  logic [ADDR_BITS-1:0]       req_new_start,
   input  logic [ADDR_BITS-1:0]       req_new_end,
   input  logic [FLAG_BITS-1:0]       req_new_flags,
   output logic                       head_valid,
   output srt_pkg::srt_tag_type       head_tag,
   output logic [ADDR_BITS-1:0]       head_addr,
   output logic [ADDR_BITS-1:0]       head_start,
   output logic [ADDR_BITS-1:0]       head_end,
   output logic [FLAG_BITS-1:0]       head_flags,
   input  logic                       pop
);
   import srt_pkg::*;

   localparam int PTR_BITS  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_BITS = $clog2(QUEUE_DEPTH + 1);

   srt_tag_type          q_tag_ff   [QUEUE_DEPTH];
   logic [ADDR_BITS-1:0] q_addr_ff  [QUEUE_DEPTH];
   logic [ADDR_BITS-1:0] q_start_ff [QUEUE_DEPTH];
   logic [ADDR_BITS-1:0] q_end_ff   [QUEUE_DEPTH];
   logic [FLAG_BITS-1:0] q_flags_ff [QUEUE_DEPTH];

   logic [PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_BITS-1:0] fill_ff, fill_in;
   logic                 push;
   srt_tag_type          tag_in;

   assign busy       = (fill_ff == FILL_BITS'(QUEUE_DEPTH));
   assign push       = start & ~busy;
   assign head_valid = (fill_ff != '0);
   assign head_tag   = q_tag_ff[rd_ptr_ff];
   assign head_addr  = q_addr_ff[rd_ptr_ff];
   assign head_start = q_start_ff[rd_ptr_ff];
   assign head_end   = q_end_ff[rd_ptr_ff];
   assign head_flags = q_flags_ff[rd_ptr_ff];

   always_comb begin
      case (req_operation)
         OP_LOOKUP: tag_in.kind = KIND_LOOKUP;
         OP_INSERT: tag_in.kind = KIND_INSERT;
         OP_CLEAR:  tag_in.kind = KIND_CLEAR;
         default:   tag_in.kind = KIND_NOP;
      endcase
      tag_in.empty_range = (req_new_start >= req_new_end);
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   fill_in = fill_ff + 1'b1;
         2'b01:   fill_in = fill_ff - 1'b1;
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_tag_ff[wr_ptr_ff]   <= tag_in;
         q_addr_ff[wr_ptr_ff]  <= req_lookup_address;
         q_start_ff[wr_ptr_ff] <= req_new_start;
         q_end_ff[wr_ptr_ff]   <= req_new_end;
         q_flags_ff[wr_ptr_ff] <= req_new_flags;
      end
   end

endmodule

`default_nettype wire

/* hdl/srt_back.sv */
// Command back end: region memory, last-hit cache, lookup scan and sorted insert.
`default_nettype none

module srt_back #(
   parameter int MAX_REGIONS = srt_pkg::DEF_MAX_REGIONS,
   parameter int ADDR_BITS   = srt_pkg::DEF_ADDR_BITS,
   parameter int FLAG_BITS   = srt_pkg::DEF_FLAG_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            head_valid,
   input  srt_pkg::srt_tag_type            head_tag,
   input  logic [ADDR_BITS-1:0]            head_addr,
   input  logic [ADDR_BITS-1:0]            head_start,
   input  logic [ADDR_BITS-1:0]            head_end,
   input  logic [FLAG_BITS-1:0]            head_flags,
   output logic                            pop,
   output logic                            rsp_strobe,
   output logic [srt_pkg::STATUS_BITS-1:0] rsp_status,
   output logic                            rsp_found,
   output logic [ADDR_BITS-1:0]            rsp_hit_start,
   output logic [ADDR_BITS-1:0]            rsp_hit_end,
   output logic [FLAG_BITS-1:0]            rsp_hit_flags,
   output logic [$clog2(MAX_REGIONS)-1:0]  rsp_slot_index,
   output logic [$clog2(MAX_REGIONS+1)-1:0] rsp_region_count
);
   import srt_pkg::*;

   localparam int SLOT_BITS  = $clog2(MAX_REGIONS);
   localparam int COUNT_BITS = $clog2(MAX_REGIONS + 1);

   logic [ADDR_BITS-1:0] region_starts_ff [MAX_REGIONS];
   logic [ADDR_BITS-1:0] region_ends_ff   [MAX_REGIONS];
   logic [FLAG_BITS-1:0] region_flags_ff  [MAX_REGIONS];

   srt_state_type         state_ff, state_in;
   logic [ADDR_BITS-1:0]  cmd_addr_ff, cmd_addr_in;
   logic [ADDR_BITS-1:0]  cmd_start_ff, cmd_start_in;
   logic [ADDR_BITS-1:0]  cmd_end_ff, cmd_end_in;
   logic [FLAG_BITS-1:0]  cmd_flags_ff, cmd_flags_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [SLOT_BITS-1:0]  cache_slot_ff, cache_slot_in;
   logic                  cache_valid_ff, cache_valid_in;
   logic [COUNT_BITS-1:0] idx_ff, idx_in;
   logic [COUNT_BITS-1:0] pos_ff, pos_in;
   logic [ADDR_BITS-1:0]  prev_end_ff, prev_end_in;
   logic [ADDR_BITS-1:0]  next_start_ff, next_start_in;
   logic                  has_next_ff, has_next_in;
   logic                  rvalid_ff;
   logic [SLOT_BITS-1:0]  rd_slot_ff;
   logic [ADDR_BITS-1:0]  rd_start_ff;
   logic [ADDR_BITS-1:0]  rd_end_ff;
   logic [FLAG_BITS-1:0]  rd_flags_ff;

   logic                   rsp_strobe_ff, rsp_strobe_in;
   logic [STATUS_BITS-1:0] rsp_status_ff, rsp_status_in;
   logic                   rsp_found_ff, rsp_found_in;
   logic [ADDR_BITS-1:0]   rsp_hit_start_ff, rsp_hit_start_in;
   logic [ADDR_BITS-1:0]   rsp_hit_end_ff, rsp_hit_end_in;
   logic [FLAG_BITS-1:0]   rsp_hit_flags_ff, rsp_hit_flags_in;
   logic [SLOT_BITS-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [COUNT_BITS-1:0]  rsp_count_ff, rsp_count_in;

   logic                  mem_re;
   logic [SLOT_BITS-1:0]  mem_raddr;
   logic                  mem_we;
   logic [SLOT_BITS-1:0]  mem_waddr;
   logic [ADDR_BITS-1:0]  mem_wstart;
   logic [ADDR_BITS-1:0]  mem_wend;
   logic [FLAG_BITS-1:0]  mem_wflags;

   logic cache_usable;
   logic scan_end;
   logic rd_holds;
   logic rd_below;
   logic ins_stop;
   logic overlap;
   logic table_full;

   assign cache_usable = cache_valid_ff && (COUNT_BITS'(cache_slot_ff) < count_ff);
   assign scan_end     = (idx_ff >= count_ff);
   assign rd_holds     = (rd_start_ff <= cmd_addr_ff) && (cmd_addr_ff < rd_end_ff);
   assign rd_below     = (rd_start_ff <= cmd_start_ff);
   assign ins_stop     = rvalid_ff && !rd_below;
   assign overlap      = ((pos_ff != '0) && (prev_end_ff > cmd_start_ff)) ||
                         (has_next_ff && (cmd_end_ff > next_start_ff));
   assign table_full   = (count_ff >= COUNT_BITS'(MAX_REGIONS));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (head_valid) begin
               case (head_tag.kind)
                  KIND_LOOKUP: state_in = cache_usable ? S_LK_CACHE : S_LK_SCAN;
                  KIND_INSERT: state_in = head_tag.empty_range ? S_IDLE : S_IN_SCAN;
                  default:     state_in = S_IDLE;
               endcase
            end
         end
         S_LK_CACHE:  state_in = S_LK_CHECK;
         S_LK_CHECK:  state_in = rd_holds ? S_IDLE : S_LK_SCAN;
         S_LK_SCAN:   state_in = ((rvalid_ff && rd_holds) || scan_end) ? S_IDLE : S_LK_SCAN;
         S_IN_SCAN:   state_in = (ins_stop || scan_end) ? S_IN_DECIDE : S_IN_SCAN;
         S_IN_DECIDE: state_in = (overlap || table_full) ? S_IDLE : S_IN_SHIFT;
         S_IN_SHIFT:  state_in = ((idx_ff == pos_ff) && !rvalid_ff) ? S_IN_PLACE : S_IN_SHIFT;
         S_IN_PLACE:  state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   always_comb begin
      pop              = 1'b0;
      cmd_addr_in      = cmd_addr_ff;
      cmd_start_in     = cmd_start_ff;
      cmd_end_in       = cmd_end_ff;
      cmd_flags_in     = cmd_flags_ff;
      count_in         = count_ff;
      cache_slot_in    = cache_slot_ff;
      cache_valid_in   = cache_valid_ff;
      idx_in           = idx_ff;
      pos_in           = pos_ff;
      prev_end_in      = prev_end_ff;
      next_start_in    = next_start_ff;
      has_next_in      = has_next_ff;
      mem_re           = 1'b0;
      mem_raddr        = '0;
      mem_we           = 1'b0;
      mem_waddr        = '0;
      mem_wstart       = rd_start_ff;
      mem_wend         = rd_end_ff;
      mem_wflags       = rd_flags_ff;
      rsp_strobe_in    = 1'b0;
      rsp_status_in    = STATUS_OK;
      rsp_found_in     = 1'b0;
      rsp_hit_start_in = '0;
      rsp_hit_end_in   = '0;
      rsp_hit_flags_in = '0;
      rsp_slot_in      = '0;
      rsp_count_in     = count_ff;
      case (state_ff)
         S_IDLE: begin
            if (head_valid) begin
               pop          = 1'b1;
               cmd_addr_in  = head_addr;
               cmd_start_in = head_start;
               cmd_end_in   = head_end;
               cmd_flags_in = head_flags;
               idx_in       = '0;
               pos_in       = '0;
               has_next_in  = 1'b0;
               case (head_tag.kind)
                  KIND_LOOKUP: begin
                  end
                  KIND_INSERT: begin
                     if (head_tag.empty_range) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = STATUS_EMPTY;
                     end
                  end
                  KIND_CLEAR: begin
                     count_in       = '0;
                     cache_slot_in  = '0;
                     cache_valid_in = 1'b0;
                     rsp_strobe_in  = 1'b1;
                     rsp_count_in   = '0;
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end
         S_LK_CACHE: begin
            mem_re    = 1'b1;
            mem_raddr = cache_slot_ff;
         end
         S_LK_CHECK: begin
            if (rd_holds) begin
               rsp_strobe_in    = 1'b1;
               rsp_found_in     = 1'b1;
               rsp_hit_start_in = rd_start_ff;
               rsp_hit_end_in   = rd_end_ff;
               rsp_hit_flags_in = rd_flags_ff;
               rsp_slot_in      = rd_slot_ff;
            end
         end
         S_LK_SCAN: begin
            if (!scan_end) begin
               mem_re    = 1'b1;
               mem_raddr = idx_ff[SLOT_BITS-1:0];
               idx_in    = idx_ff + 1'b1;
            end
            if (rvalid_ff && rd_holds) begin
               cache_slot_in    = rd_slot_ff;
               cache_valid_in   = 1'b1;
               rsp_strobe_in    = 1'b1;
               rsp_found_in     = 1'b1;
               rsp_hit_start_in = rd_start_ff;
               rsp_hit_end_in   = rd_end_ff;
               rsp_hit_flags_in = rd_flags_ff;
               rsp_slot_in      = rd_slot_ff;
            end else if (scan_end) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = STATUS_NOT_FOUND;
            end
         end
         S_IN_SCAN: begin
            if (!scan_end) begin
               mem_re    = 1'b1;
               mem_raddr = idx_ff[SLOT_BITS-1:0];
               idx_in    = idx_ff + 1'b1;
            end
            if (rvalid_ff) begin
               if (rd_below) begin
                  prev_end_in = rd_end_ff;
                  pos_in      = COUNT_BITS'(rd_slot_ff) + COUNT_BITS'(1);
               end else begin
                  pos_in        = COUNT_BITS'(rd_slot_ff);
                  next_start_in = rd_start_ff;
                  has_next_in   = 1'b1;
               end
            end
         end
         S_IN_DECIDE: begin
            if (overlap) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = STATUS_OVERLAP;
            end else if (table_full) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = STATUS_FULL;
            end else begin
               idx_in = count_ff;
            end
         end
         S_IN_SHIFT: begin
            if (idx_ff != pos_ff) begin
               mem_re    = 1'b1;
               mem_raddr = SLOT_BITS'(idx_ff - 1'b1);
               idx_in    = idx_ff - 1'b1;
            end
            if (rvalid_ff) begin
               mem_we    = 1'b1;
               mem_waddr = rd_slot_ff + SLOT_BITS'(1);
            end
         end
         S_IN_PLACE: begin
            mem_we     = 1'b1;
            mem_waddr  = pos_ff[SLOT_BITS-1:0];
            mem_wstart = cmd_start_ff;
            mem_wend   = cmd_end_ff;
            mem_wflags = cmd_flags_ff;
            count_in   = count_ff + 1'b1;
            if (cache_valid_ff && (COUNT_BITS'(cache_slot_ff) >= pos_ff)) begin
               cache_slot_in = cache_slot_ff + SLOT_BITS'(1);
            end
            rsp_strobe_in = 1'b1;
            rsp_slot_in   = pos_ff[SLOT_BITS-1:0];
            rsp_count_in  = count_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         region_starts_ff[mem_waddr] <= mem_wstart;
         region_ends_ff[mem_waddr]   <= mem_wend;
         region_flags_ff[mem_waddr]  <= mem_wflags;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_start_ff <= region_starts_ff[mem_raddr];
         rd_end_ff   <= region_ends_ff[mem_raddr];
         rd_flags_ff <= region_flags_ff[mem_raddr];
         rd_slot_ff  <= mem_raddr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         count_ff       <= '0;
         cache_slot_ff  <= '0;
         cache_valid_ff <= 1'b0;
         rvalid_ff      <= 1'b0;
         rsp_strobe_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         count_ff       <= count_in;
         cache_slot_ff  <= cache_slot_in;
         cache_valid_ff <= cache_valid_in;
         rvalid_ff      <= mem_re;
         rsp_strobe_ff  <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_addr_ff      <= cmd_addr_in;
      cmd_start_ff     <= cmd_start_in;
      cmd_end_ff       <= cmd_end_in;
      cmd_flags_ff     <= cmd_flags_in;
      idx_ff           <= idx_in;
      pos_ff           <= pos_in;
      prev_end_ff      <= prev_end_in;
      next_start_ff    <= next_start_in;
      has_next_ff      <= has_next_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_found_ff     <= rsp_found_in;
      rsp_hit_start_ff <= rsp_hit_start_in;
      rsp_hit_end_ff   <= rsp_hit_end_in;
      rsp_hit_flags_ff <= rsp_hit_flags_in;
      rsp_slot_ff      <= rsp_slot_in;
      rsp_count_ff     <= rsp_count_in;
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_hit_start    = rsp_hit_start_ff;
   assign rsp_hit_end      = rsp_hit_end_ff;
   assign rsp_hit_flags    = rsp_hit_flags_ff;
   assign rsp_slot_index   = rsp_slot_ff;
   assign rsp_region_count = rsp_count_ff;

endmodule

`default_nettype wire

/* hdl/sorted_region_table_core.sv */
// Top level of the sorted region table: command queue front end and table back end.
//
//   Channel   Handshake            Payload
//   request   start / busy         req_operation, req_lookup_address, req_new_start,
//                                  req_new_end, req_new_flags
//   response  rsp_strobe (1 cycle) rsp_status, rsp_found, rsp_hit_start, rsp_hit_end,
//                                  rsp_hit_flags, rsp_slot_index, rsp_region_count
//
// Clear, unused codes and empty-range inserts finish in the idle state of the back end.
// Lookups and inserts walk the region memory one entry a cycle via its single read port.
// The response appears the cycle after the back end finishes; it cannot be held off.
// The queue holds two commands; busy is high while it is full.
// Reset is synchronous and empties the queue and the table; no clearing pass is needed.
`default_nettype none

module sorted_region_table_core #(
   parameter int MAX_REGIONS = srt_pkg::DEF_MAX_REGIONS,
   parameter int ADDR_BITS   = srt_pkg::DEF_ADDR_BITS,
   parameter int FLAG_BITS   = srt_pkg::DEF_FLAG_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [srt_pkg::OP_BITS-1:0]      req_operation,
   input  logic [ADDR_BITS-1:0]             req_lookup_address,
   input  logic [ADDR_BITS-1:0]             req_new_start,
   input  logic [ADDR_BITS-1:0]             req_new_end,
   input  logic [FLAG_BITS-1:0]             req_new_flags,
   output logic                             rsp_strobe,
   output logic [srt_pkg::STATUS_BITS-1:0]  rsp_status,
   output logic                             rsp_found,
   output logic [ADDR_BITS-1:0]             rsp_hit_start,
   output logic [ADDR_BITS-1:0]             rsp_hit_end,
   output logic [FLAG_BITS-1:0]             rsp_hit_flags,
   output logic [$clog2(MAX_REGIONS)-1:0]   rsp_slot_index,
   output logic [$clog2(MAX_REGIONS+1)-1:0] rsp_region_count
);
   import srt_pkg::*;

   logic                 head_valid;
   srt_tag_type          head_tag;
   logic [ADDR_BITS-1:0] head_addr;
   logic [ADDR_BITS-1:0] head_start;
   logic [ADDR_BITS-1:0] head_end;
   logic [FLAG_BITS-1:0] head_flags;
   logic                 pop;

   srt_front #(
      .ADDR_BITS (ADDR_BITS),
      .FLAG_BITS (FLAG_BITS)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_operation      (req_operation),
      .req_lookup_address (req_lookup_address),
      .req_new_start      (req_new_start),
      .req_new_end        (req_new_end),
      .req_new_flags      (req_new_flags),
      .head_valid         (head_valid),
      .head_tag           (head_tag),
      .head_addr          (head_addr),
      .head_start         (head_start),
      .head_end           (head_end),
      .head_flags         (head_flags),
      .pop                (pop)
   );

   srt_back #(
      .MAX_REGIONS (MAX_REGIONS),
      .ADDR_BITS   (ADDR_BITS),
      .FLAG_BITS   (FLAG_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (head_valid),
      .head_tag         (head_tag),
      .head_addr        (head_addr),
      .head_start       (head_start),
      .head_end         (head_end),
      .head_flags       (head_flags),
      .pop              (pop),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_found        (rsp_found),
      .rsp_hit_start    (rsp_hit_start),
      .rsp_hit_end      (rsp_hit_end),
      .rsp_hit_flags    (rsp_hit_flags),
      .rsp_slot_index   (rsp_slot_index),
      .rsp_region_count (rsp_region_count)
   );

endmodule

`default_nettype wire

/* hdl/srt_checker.sv */
// Port-level assertions for the sorted region table and their bind to the top level.
`default_nettype none

module srt_checker #(
   parameter int MAX_REGIONS = srt_pkg::DEF_MAX_REGIONS,
   parameter int ADDR_BITS   = srt_pkg::DEF_ADDR_BITS,
   parameter int FLAG_BITS   = srt_pkg::DEF_FLAG_BITS
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_strobe,
   input logic [srt_pkg::STATUS_BITS-1:0]  rsp_status,
   input logic                             rsp_found,
   input logic [ADDR_BITS-1:0]             rsp_hit_start,
   input logic [ADDR_BITS-1:0]             rsp_hit_end,
   input logic [FLAG_BITS-1:0]             rsp_hit_flags,
   input logic [$clog2(MAX_REGIONS+1)-1:0] rsp_region_count
);
   import srt_pkg::*;

   localparam int COUNT_BITS = $clog2(MAX_REGIONS + 1);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_strobe)
      else $error("Response beat right after reset.");

   a_miss_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_found) |->
         (rsp_hit_start == '0 && rsp_hit_end == '0 && rsp_hit_flags == '0))
      else $error("Hit fields not zero on a beat without a match.");

   a_hit_region: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_found) |-> (rsp_status == STATUS_OK && rsp_hit_start < rsp_hit_end))
      else $error("Matched region is not a valid range or status is not ok.");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_region_count <= COUNT_BITS'(MAX_REGIONS)))
      else $error("Region count exceeds the table size.");

endmodule

bind sorted_region_table_core srt_checker #(
   .MAX_REGIONS (MAX_REGIONS),
   .ADDR_BITS   (ADDR_BITS),
   .FLAG_BITS   (FLAG_BITS)
) u_srt_checker (.*);

`default_nettype wire
